### hw/rtl/pdsd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdsd_pkg: shared types and codes of the PWM duty to speed decoder
// Request codes, capture modes, register indexes and divider handshake types.
// -----------------------------------------------------------------------------
package pdsd_pkg;

   localparam int FieldW = 16;
   localparam int ProdW  = 2 * FieldW;
   localparam int CntW   = $clog2(ProdW);

   // request codes
   localparam logic [1:0] REQ_RISE     = 2'd0;
   localparam logic [1:0] REQ_FALL     = 2'd1;
   localparam logic [1:0] REQ_OVERFLOW = 2'd2;

   // capture modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_STARTED = 2'd1;
   localparam logic [1:0] MODE_FALL    = 2'd2;
   localparam logic [1:0] MODE_HOLD    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_FULL_SPEED  = 2'd0;
   localparam logic [1:0] CSR_FLOOR_SPEED = 2'd1;
   localparam logic [1:0] CSR_ENABLE      = 2'd2;

   typedef struct packed {
      logic              start;
      logic [ProdW-1:0]  dividend;
      logic [FieldW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [ProdW-1:0] quotient;
   } div_rsp_type;

endpackage

### hw/rtl/pdsd_divider.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pdsd_divider: serial restoring divider
// One quotient bit per cycle, 32-bit dividend over 16-bit nonzero divisor.
// -----------------------------------------------------------------------------
module pdsd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pdsd_pkg::div_req_type div_req,
   output pdsd_pkg::div_rsp_type div_rsp
);

   logic [pdsd_pkg::ProdW-1:0]  quo_ff, quo_in;
   logic [pdsd_pkg::FieldW-1:0] rem_ff, rem_in;
   logic [pdsd_pkg::FieldW-1:0] dsr_ff, dsr_in;
   logic [pdsd_pkg::CntW-1:0]   cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [pdsd_pkg::FieldW:0]   trial;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[pdsd_pkg::ProdW-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = pdsd_pkg::FieldW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[pdsd_pkg::FieldW-1:0];
         end
         quo_in = {quo_ff[pdsd_pkg::ProdW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pdsd_pkg::CntW'(pdsd_pkg::ProdW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### hw/rtl/pwm_duty_to_speed_decoder_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pwm_duty_to_speed_decoder_unit: PWM capture events to motor speed commands
// Tracks capture mode and last (high, period) pair; emits run/speed on change.
// -----------------------------------------------------------------------------
// Each accepted item is a capture event (rising with high time and period,
// falling, or counter overflow). The capture mode and stored pair update in
// the accept cycle. A new pair with a nonzero period produces a run command
// with speed = floor(full_speed * high / period), raised to floor_speed and
// saturated at 65535; a zero period gives a stop (run 0, speed 0). The speed
// path is one 16x16 multiply into a serial restoring divider that resolves one
// quotient bit per cycle. A speed item holds req_ready low through the product
// load (ST_MUL), the 32 divide steps until done is seen (ST_DIV) and the
// result load (ST_DONE); a stop item holds it low for the result load only,
// and events with no result free the block at once. While the output register
// still holds an unaccepted result, a finished item waits for it in ST_DONE,
// which keeps req_ready low longer. An item can be accepted while the previous
// result still waits on rsp_ready. Registers are to be written through the
// csr port only while idle, by the user; the block does not enforce this.
// Writing enable to 1 restarts the mode and clears the stored pair.
// -----------------------------------------------------------------------------
module pwm_duty_to_speed_decoder_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // events
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_high_time,
   input  logic [15:0] req_period_time,
   // commands
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_run,
   output logic [15:0] rsp_speed,
   // registers
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int CapW = (COUNT_WIDTH < pdsd_pkg::FieldW) ? COUNT_WIDTH : pdsd_pkg::FieldW;
   localparam logic [pdsd_pkg::FieldW-1:0] CapMask =
      pdsd_pkg::FieldW'((17'(1) << CapW) - 17'(1));

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [15:0] full_speed_ff, full_speed_in;
   logic [15:0] floor_speed_ff, floor_speed_in;
   logic        enable_ff, enable_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] last_high_ff, last_high_in;
   logic [15:0] last_period_ff, last_period_in;
   logic [1:0]  state_ff, state_in;
   logic        run_pend_ff, run_pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_run_ff, rsp_run_in;
   logic [15:0] rsp_speed_ff, rsp_speed_in;

   logic        accept;
   logic        offer;
   logic [15:0] offer_high, offer_period;
   logic [1:0]  event_mode;
   logic        is_new;
   logic [15:0] cap_high, cap_period;
   logic [15:0] q_sat;
   logic        out_free;

   pdsd_pkg::div_req_type div_req;
   pdsd_pkg::div_rsp_type div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cap_high   = req_high_time & CapMask;
   assign cap_period = req_period_time & CapMask;

   // event decode: what pair is offered and where the mode goes
   always_comb begin
      offer        = 1'b0;
      offer_high   = '0;
      offer_period = '0;
      event_mode   = mode_ff;
      case (req_type)
         pdsd_pkg::REQ_RISE: begin
            offer        = (mode_ff == pdsd_pkg::MODE_FALL);
            offer_high   = cap_high;
            offer_period = cap_period;
            event_mode   = pdsd_pkg::MODE_STARTED;
         end
         pdsd_pkg::REQ_FALL: begin
            event_mode = pdsd_pkg::MODE_FALL;
         end
         pdsd_pkg::REQ_OVERFLOW: begin
            if (mode_ff == pdsd_pkg::MODE_IDLE || mode_ff == pdsd_pkg::MODE_FALL) begin
               offer      = 1'b1;
               event_mode = pdsd_pkg::MODE_IDLE;
            end else if (mode_ff == pdsd_pkg::MODE_STARTED) begin
               offer        = 1'b1;
               offer_high   = 16'd1;
               offer_period = 16'd1;
               event_mode   = pdsd_pkg::MODE_HOLD;
            end
         end
         default: begin
            // unused code: ignored
         end
      endcase
   end

   assign is_new = offer && ((offer_high != last_high_ff) || (offer_period != last_period_ff));

   // divider feed: product registered inside the divider on start
   assign div_req.start    = (state_ff == ST_MUL);
   assign div_req.dividend = pdsd_pkg::ProdW'(full_speed_ff) * pdsd_pkg::ProdW'(last_high_ff);
   assign div_req.divisor  = last_period_ff;

   pdsd_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // raise to floor_speed, then saturate
   always_comb begin
      if (div_rsp.quotient[pdsd_pkg::ProdW-1:pdsd_pkg::FieldW] != '0) begin
         q_sat = 16'hffff;
      end else if (div_rsp.quotient[pdsd_pkg::FieldW-1:0] < floor_speed_ff) begin
         q_sat = floor_speed_ff;
      end else begin
         q_sat = div_rsp.quotient[pdsd_pkg::FieldW-1:0];
      end
   end

   always_comb begin
      full_speed_in  = full_speed_ff;
      floor_speed_in = floor_speed_ff;
      enable_in      = enable_ff;
      mode_in        = mode_ff;
      last_high_in   = last_high_ff;
      last_period_in = last_period_ff;
      state_in       = state_ff;
      run_pend_in    = run_pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_run_in     = rsp_run_ff;
      rsp_speed_in   = rsp_speed_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            pdsd_pkg::CSR_FULL_SPEED:  full_speed_in  = csr_write_data;
            pdsd_pkg::CSR_FLOOR_SPEED: floor_speed_in = csr_write_data;
            pdsd_pkg::CSR_ENABLE: begin
               enable_in = csr_write_data[0];
               if (csr_write_data[0]) begin
                  mode_in        = pdsd_pkg::MODE_IDLE;
                  last_high_in   = '0;
                  last_period_in = '0;
               end
            end
            default: begin
               // no register at this index
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && enable_ff) begin
               mode_in = event_mode;
               if (is_new) begin
                  last_high_in   = offer_high;
                  last_period_in = offer_period;
                  run_pend_in    = (offer_period != '0);
                  state_in       = (offer_period != '0) ? ST_MUL : ST_DONE;
               end
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_run_in   = run_pend_ff;
               rsp_speed_in = run_pend_ff ? q_sat : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_speed_ff  <= 16'd1000;
         floor_speed_ff <= 16'd100;
         enable_ff      <= 1'b0;
         mode_ff        <= pdsd_pkg::MODE_IDLE;
         last_high_ff   <= '0;
         last_period_ff <= '0;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         full_speed_ff  <= full_speed_in;
         floor_speed_ff <= floor_speed_in;
         enable_ff      <= enable_in;
         mode_ff        <= mode_in;
         last_high_ff   <= last_high_in;
         last_period_ff <= last_period_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      run_pend_ff  <= run_pend_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_run   = rsp_run_ff;
   assign rsp_speed = rsp_speed_ff;

endmodule
